>>> rtl/core/fpsa_pkg.sv
// Shared types and constants for the free page stack allocator.
package fpsa_pkg;

    localparam int unsigned STACK_DEPTH = 65536;
    localparam int unsigned PAGE_BYTES  = 4096;
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int unsigned PAGE_NUM_W  = ADDR_W - PAGE_SHIFT;
    localparam int unsigned STACK_AW    = $clog2(STACK_DEPTH);
    localparam int unsigned COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int unsigned CFG_IDX_W   = 2;

    typedef enum logic [1:0] {
        OP_FREE  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_RANGE = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_BAD   = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAP_START  = 2'd0,
        CFG_KERNEL_BASE = 2'd1,
        CFG_PHYS_TOP    = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_POP,
        S_CLEAR
    } fsm_state_t;

    typedef struct packed {
        op_t               operation;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] range_end;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [ADDR_W-1:0]  page_address;
        logic [COUNT_W-1:0] free_count;
    } resp_t;

endpackage

>>> rtl/core/fpsa_stack_ram.sv
// Single-port-write, registered-read memory that holds the stacked page numbers.
module fpsa_stack_ram
    import fpsa_pkg::*;
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [STACK_AW-1:0]   wr_addr,
    input  logic [PAGE_NUM_W-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [STACK_AW-1:0]   rd_addr,
    output logic [PAGE_NUM_W-1:0] rd_data
);

    logic [PAGE_NUM_W-1:0] mem [STACK_DEPTH];
    logic [PAGE_NUM_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read register holds its value until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/free_page_stack_allocator.sv
// Top level of the free page stack allocator: control, address checks and result register.
//
//  Channel   Signals                          Direction  Moves
//  request   in_valid, in_stall, in_data      in         one operation (req_t)
//  result    out_valid, out_stall, out_data   out        one result per request (resp_t)
//  config    cfg_valid, cfg_ready, cfg_index, in         one register write
//            cfg_data
//
// A free, allocate or clear request is accepted in the idle state and executed in the
// state after it; the allocate issues its stack memory read as it is accepted.
// A free-range request pushes its pages one after another, since every
// page is one write into the single write port of the stack memory.
// After reset the stack is empty; the stack memory needs no clearing pass because
// only entries below the stack top are ever read.
// The final step of a request waits while the result register holds an untaken
// result; a new request is accepted as soon as the previous one has finished.
module free_page_stack_allocator
    import fpsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  req_t                 in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output resp_t                out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    localparam logic [ADDR_W:0]    PAGE_OFS   = (ADDR_W+1)'(PAGE_BYTES - 1);
    localparam logic [ADDR_W+1:0]  PAGE_STEP  = (ADDR_W+2)'(PAGE_BYTES);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(STACK_DEPTH);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    // Configuration registers.
    logic [ADDR_W-1:0] heap_start_reg;
    logic [ADDR_W-1:0] kernel_base_reg;
    logic [ADDR_W-1:0] phys_top_reg;

    // Request context. cur_reg carries one extra bit because rounding a range
    // start up to a page can pass the top of the address space.
    logic              single_reg;
    logic [ADDR_W:0]   cur_reg;
    logic [ADDR_W-1:0] end_reg;
    logic [COUNT_W-1:0] top_reg;

    logic  out_valid_reg;
    resp_t out_data_reg;

    logic                  in_acc;
    logic                  out_free;
    logic [ADDR_W:0]       start_up;
    logic [ADDR_W-1:0]     addr_lo;
    logic [ADDR_W-1:0]     phys;
    logic                  range_done;
    logic                  addr_bad;
    logic                  stack_full;
    logic                  finish_req;
    logic                  push_req;
    logic                  go;
    logic                  finish;
    logic                  wr_en;
    logic                  rd_en;
    logic [COUNT_W-1:0]    top_after;
    logic [PAGE_NUM_W-1:0] rd_data;
    resp_t                 res;

    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Range start rounded up to a whole page, without wrap.
    assign start_up = ({1'b0, in_data.address} + PAGE_OFS)
                      & ~(ADDR_W+1)'(PAGE_BYTES - 1);

    // Checks on the page under work.
    assign addr_lo    = cur_reg[ADDR_W-1:0];
    assign phys       = addr_lo - kernel_base_reg;
    assign range_done = !single_reg && (({1'b0, cur_reg} + PAGE_STEP) > {2'b00, end_reg});
    assign addr_bad   = (single_reg && (cur_reg[PAGE_SHIFT-1:0] != '0))
                        || (addr_lo < heap_start_reg)
                        || (phys >= phys_top_reg);
    assign stack_full = (top_reg == FULL_COUNT);

    fpsa_stack_ram u_stack_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (top_reg[STACK_AW-1:0]),
        .wr_data (cur_reg[ADDR_W-1:PAGE_SHIFT]),
        .rd_en   (rd_en),
        .rd_addr (top_after[STACK_AW-1:0]),
        .rd_data (rd_data)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (in_data.operation)
                        OP_FREE,
                        OP_RANGE: state_next = S_PUSH;
                        OP_ALLOC: state_next = S_POP;
                        OP_CLEAR: state_next = S_CLEAR;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_PUSH,
            S_POP,
            S_CLEAR:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs of the state machine. A step that ends the request only takes
    // effect when the result register can take its result.
    always_comb
    begin
        in_stall         = 1'b1;
        finish_req       = 1'b0;
        push_req         = 1'b0;
        rd_en            = 1'b0;
        top_after        = top_reg;
        res.status       = STAT_OK;
        res.page_address = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                // Address the top entry so an allocate finds it in the read register in the pop state.
                top_after = top_reg - COUNT_W'(1);
                rd_en     = in_acc && (in_data.operation == OP_ALLOC) && (top_reg != '0);
            end
            S_PUSH:
            begin
                if (range_done)
                begin
                    finish_req = 1'b1;
                end
                else if (addr_bad)
                begin
                    finish_req = 1'b1;
                    res.status = STAT_BAD;
                end
                else if (stack_full)
                begin
                    finish_req = 1'b1;
                    res.status = STAT_FULL;
                end
                else
                begin
                    push_req   = 1'b1;
                    finish_req = single_reg;
                    top_after  = top_reg + COUNT_W'(1);
                end
            end
            S_POP:
            begin
                finish_req = 1'b1;
                if (top_reg != '0)
                begin
                    top_after        = top_reg - COUNT_W'(1);
                    res.page_address = {rd_data, PAGE_SHIFT'(0)};
                end
                else
                begin
                    res.status = STAT_EMPTY;
                end
            end
            S_CLEAR:
            begin
                finish_req = 1'b1;
                top_after  = '0;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
        res.free_count = top_after;
    end

    assign go     = (state_reg != S_IDLE) && (!finish_req || out_free);
    assign finish = finish_req && go;
    assign wr_en  = push_req && go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            top_reg         <= '0;
            out_valid_reg   <= 1'b0;
            heap_start_reg  <= '0;
            kernel_base_reg <= 32'h8000_0000;
            phys_top_reg    <= 32'h0E00_0000;
        end
        else
        begin
            state_reg <= state_next;
            if (go)
            begin
                top_reg <= top_after;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_HEAP_START:  heap_start_reg  <= cfg_data;
                    CFG_KERNEL_BASE: kernel_base_reg <= cfg_data;
                    CFG_PHYS_TOP:    phys_top_reg    <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    // Request context and result payload.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            single_reg <= (in_data.operation == OP_FREE);
            cur_reg    <= (in_data.operation == OP_FREE) ? {1'b0, in_data.address} : start_up;
            end_reg    <= in_data.range_end;
        end
        else if (wr_en)
        begin
            cur_reg <= cur_reg + (ADDR_W+1)'(PAGE_BYTES);
        end
        if (finish)
        begin
            out_data_reg <= res;
        end
    end

    // The stack never holds more pages than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n) top_reg <= FULL_COUNT)
        else $error("stack top beyond depth");

    // A push is only written while there is room for it and its address is good.
    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> !stack_full && !addr_bad)
        else $error("push written into a full stack or for a bad address");

    // An accepted allocate goes to the memory read step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_data.operation == OP_ALLOC)) |=> (state_reg == S_POP))
        else $error("allocate did not reach the read step");

    // An empty-stack result carries no page and an empty count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == STAT_EMPTY))
        |-> (out_data.page_address == '0) && (out_data.free_count == '0))
        else $error("empty result with a page or a nonzero count");

    // A result is loaded only when the previous one has been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while stalled");

endmodule

>>> tb/free_page_stack_allocator_test.sv
// Self-checking testbench for the free page stack allocator: directed table, then random phases.
module free_page_stack_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fpsa_pkg::*;

    // Register index that decodes to nothing; a write to it must leave every setting alone.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [ADDR_W-1:0] PAGE_LOW_MASK = PAGE_BYTES - 1;

    // Eight random phases of two hundred requests each, one register setting per phase.
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 200;

    // The slowest legal stretch without any handshake is a free-range that fills the
    // whole stack, pushing its STACK_DEPTH pages one after another. The limit sits
    // several times above that.
    localparam int WATCHDOG_LIMIT = 4 * STACK_DEPTH + 20000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    req_t                 in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    resp_t                out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_data  = '0;

    free_page_stack_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Mirror of the allocator. It keeps its own copy of the three settings and of
    // the page stack, and turns each accepted request into the result the block
    // has to return for it.
    // ------------------------------------------------------------------------
    logic [ADDR_W-1:0]     heap_floor  = '0;
    logic [ADDR_W-1:0]     virt_offset = 32'h8000_0000;
    logic [ADDR_W-1:0]     phys_limit  = 32'h0E00_0000;
    logic [PAGE_NUM_W-1:0] mirror_stack [STACK_DEPTH];
    int unsigned           free_depth  = 0;

    // Results still owed by the block, oldest first.
    resp_t awaited_results [$];
    int    error_count = 0;

    // A page is only taken if it is page aligned, not below the heap floor, and its
    // physical address (virtual minus offset, wrapping) lies below the physical limit.
    // Only then does a full stack matter.
    function automatic status_t push_free_page(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] phys;
        phys = addr - virt_offset;
        if ((addr & PAGE_LOW_MASK) != 0 || addr < heap_floor || phys >= phys_limit)
            return STAT_BAD;
        if (free_depth >= STACK_DEPTH)
            return STAT_FULL;
        mirror_stack[free_depth] = addr[ADDR_W-1:PAGE_SHIFT];
        free_depth++;
        return STAT_OK;
    endfunction

    function automatic resp_t stack_outcome(input req_t r);
        resp_t             res;
        status_t           st;
        logic [ADDR_W-1:0] page;
        logic [63:0]       cursor;
        logic [63:0]       limit;
        bit                going;
        st   = STAT_OK;
        page = '0;
        case (r.operation)
            OP_FREE:
                st = push_free_page(r.address);
            OP_ALLOC:
            begin
                if (free_depth > 0)
                begin
                    free_depth--;
                    page = ADDR_W'(mirror_stack[free_depth]) << PAGE_SHIFT;
                end
                else
                    st = STAT_EMPTY;
            end
            OP_RANGE:
            begin
                // Round the start up in 64 bits, so a start that rounds past the top of
                // the address space yields an empty range instead of wrapping to zero.
                cursor = ((64'(r.address) + PAGE_BYTES - 1) >> PAGE_SHIFT) << PAGE_SHIFT;
                limit  = 64'(r.range_end);
                going  = 1'b1;
                while (going && cursor + PAGE_BYTES <= limit)
                begin
                    st = push_free_page(cursor[ADDR_W-1:0]);
                    if (st != STAT_OK)
                        going = 1'b0;
                    else
                        cursor += PAGE_BYTES;
                end
            end
            default:
                free_depth = 0;
        endcase
        res.status       = st;
        res.page_address = page;
        res.free_count   = COUNT_W'(free_depth);
        return res;
    endfunction

    function automatic resp_t make_result(input status_t st, input logic [ADDR_W-1:0] page,
                                          input int unsigned count);
        resp_t res;
        res.status       = st;
        res.page_address = page;
        res.free_count   = COUNT_W'(count);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: the receiver stalls in modes that it picks anew each time its
    // countdown runs out: never, about half of the time, or most of the time.
    // ------------------------------------------------------------------------
    int stall_mode = 0;
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(32, 400);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 1) != 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Every taken result is checked, field by field, against the oldest one owed.
    always @(posedge clk)
    begin : check_results
        resp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
                report_mismatch($sformatf("result with no request outstanding: %0d %h %0d",
                                          out_data.status, out_data.page_address,
                                          out_data.free_count));
            else
            begin
                want = awaited_results.pop_front();
                if (out_data.status != want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              out_data.status, want.status));
                if (out_data.page_address != want.page_address)
                    report_mismatch($sformatf("page_address %h, expected %h",
                                              out_data.page_address, want.page_address));
                if (out_data.free_count != want.free_count)
                    report_mismatch($sformatf("free_count %0d, expected %0d",
                                              out_data.free_count, want.free_count));
            end
        end
    end

    // The watchdog counts cycles without any handshake on any channel.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Request side. The sender works in bursts, and valid drops between bursts.
    // The flags below make sure valid and the config valid each get at most one
    // nonblocking update per clock edge.
    // ------------------------------------------------------------------------
    int burst_left = 0;
    bit sending    = 1'b0;
    bit writing    = 1'b0;

    task automatic close_writes();
        if (writing)
        begin
            cfg_valid <= 1'b0;
            writing = 1'b0;
        end
    endtask

    // Holds off new requests until every result owed has been taken, so the block
    // is idle afterwards.
    task automatic settle();
        if (sending)
        begin
            in_valid <= 1'b0;
            sending = 1'b0;
            do
                @(posedge clk);
            while (awaited_results.size() != 0);
        end
    endtask

    // Sends one request and records what it must produce: the typed-in result when
    // one is given, the mirror's answer otherwise. The mirror runs in both cases so
    // its stack follows the block.
    task automatic send_request(input req_t r, input bit known, input resp_t typed);
        resp_t predicted;
        close_writes();
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        sending = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        predicted = stack_outcome(r);
        awaited_results.push_back(known ? typed : predicted);
    endtask

    // One register write; the caller has settled the block first.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        writing = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_HEAP_START:  heap_floor  = value;
            CFG_KERNEL_BASE: virt_offset = value;
            CFG_PHYS_TOP:    phys_limit  = value;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [ADDR_W-1:0] heap, input logic [ADDR_W-1:0] kbase,
                                 input logic [ADDR_W-1:0] ptop);
        settle();
        write_register(CFG_HEAP_START, heap);
        write_register(CFG_KERNEL_BASE, kbase);
        write_register(CFG_PHYS_TOP, ptop);
    endtask

    // A page address inside the currently valid physical window, when there is one.
    function automatic logic [ADDR_W-1:0] window_page();
        logic [ADDR_W-1:0] phys;
        if (phys_limit < PAGE_BYTES)
            return $urandom & ~PAGE_LOW_MASK;
        phys = ADDR_W'($urandom_range(0, (phys_limit - 1) >> PAGE_SHIFT)) << PAGE_SHIFT;
        return virt_offset + phys;
    endfunction

    // Mostly well-formed traffic: frees of pages in the window, allocates, and short
    // ranges around the window, with random addresses and ends mixed in as noise.
    // Ranges mostly stay within 64 pages so the random part runs quickly.
    function automatic req_t random_request();
        req_t r;
        int   pick;
        pick        = $urandom_range(0, 99);
        r.address   = $urandom;
        r.range_end = $urandom;
        if (pick < 40)
        begin
            r.operation = OP_FREE;
            if (pick < 33)
                r.address = window_page();
        end
        else if (pick < 72)
            r.operation = OP_ALLOC;
        else if (pick < 97)
        begin
            r.operation = OP_RANGE;
            case ($urandom_range(0, 9))
                0:
                    r.range_end = r.address - $urandom_range(0, 1 << 16);
                1:
                    r.range_end = r.address + $urandom_range(0, 64 * PAGE_BYTES);
                default:
                begin
                    r.address = window_page();
                    if ($urandom_range(0, 1))
                        r.address = r.address - $urandom_range(0, PAGE_BYTES - 1);
                    r.range_end = r.address + $urandom_range(0, 12 * PAGE_BYTES);
                end
            endcase
        end
        else
            r.operation = OP_CLEAR;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table. Each row is either a register write or a request; requests
    // carry the result when it is plain from the rules, else the mirror decides.
    // ------------------------------------------------------------------------
    typedef struct {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [ADDR_W-1:0]    reg_value;
        req_t                 request;
        bit                   known;
        resp_t                result;
    } script_row_t;

    script_row_t script [$];

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [ADDR_W-1:0] value);
        script_row_t row;
        row.is_write  = 1'b1;
        row.reg_index = idx;
        row.reg_value = value;
        row.request   = '0;
        row.known     = 1'b0;
        row.result    = '0;
        script.push_back(row);
    endfunction

    function automatic void add_op(input op_t op, input logic [ADDR_W-1:0] addr,
                                   input logic [ADDR_W-1:0] rend, input bit known,
                                   input resp_t res);
        script_row_t row;
        row.is_write          = 1'b0;
        row.reg_index         = '0;
        row.reg_value         = '0;
        row.request.operation = op;
        row.request.address   = addr;
        row.request.range_end = rend;
        row.known             = known;
        row.result            = res;
        script.push_back(row);
    endfunction

    initial
    begin
        logic [ADDR_W-1:0] kb;

        // Reset values: heap floor 0, offset 0x80000000, physical limit 0x0E000000.
        // Allocate on the empty stack, with its unused fields all ones.
        add_op(OP_ALLOC, '1, '1, 1, make_result(STAT_EMPTY, '0, 0));
        add_op(OP_FREE, 32'h8000_0000, '0, 1, make_result(STAT_OK, '0, 1));
        // Misaligned page, page exactly at the physical limit.
        add_op(OP_FREE, 32'h8000_0001, '0, 1, make_result(STAT_BAD, '0, 1));
        add_op(OP_FREE, 32'h8E00_0000, '0, 1, make_result(STAT_BAD, '0, 1));
        // Last page below the limit; range_end is ignored on a single free.
        add_op(OP_FREE, 32'h8DFF_F000, '1, 1, make_result(STAT_OK, '0, 2));
        // Below the offset, so the physical address wraps to the top.
        add_op(OP_FREE, 32'h7FFF_F000, '0, 1, make_result(STAT_BAD, '0, 2));
        add_op(OP_ALLOC, '0, '0, 1, make_result(STAT_OK, 32'h8DFF_F000, 1));
        // Unaligned range start rounds up; two pages fit.
        add_op(OP_RANGE, 32'h8000_0001, 32'h8000_3000, 0, '0);
        // Start rounds past the top of the address space: empty range.
        add_op(OP_RANGE, 32'hFFFF_F001, '1, 1, make_result(STAT_OK, '0, 3));
        // Range that runs into the physical limit: earlier pages stay pushed.
        add_op(OP_RANGE, 32'h8DFF_E000, 32'h8E00_1000, 0, '0);
        // End one byte short of a whole page: nothing pushed.
        add_op(OP_RANGE, 32'h8000_5000, 32'h8000_5FFF, 1, make_result(STAT_OK, '0, 5));
        add_op(OP_CLEAR, '1, '1, 1, make_result(STAT_OK, '0, 0));
        add_op(OP_ALLOC, '0, '0, 1, make_result(STAT_EMPTY, '0, 0));

        // Highest heap floor: nothing aligned can be freed.
        add_write(CFG_HEAP_START, '1);
        add_op(OP_FREE, 32'hFFFF_F000, '0, 1, make_result(STAT_BAD, '0, 0));

        // Widest window; the write to the undecoded index must change nothing.
        add_write(CFG_HEAP_START, '0);
        add_write(CFG_KERNEL_BASE, '0);
        add_write(CFG_PHYS_TOP, '1);
        add_write(CFG_UNUSED, '0);
        // One page more than the stack holds: fills it, then reports full.
        add_op(OP_RANGE, '0, 32'h1000_1000, 1, make_result(STAT_FULL, '0, STACK_DEPTH));
        add_op(OP_FREE, 32'h1234_5000, '0, 1, make_result(STAT_FULL, '0, STACK_DEPTH));
        add_op(OP_ALLOC, '0, '0, 1, make_result(STAT_OK, 32'h0FFF_F000, STACK_DEPTH - 1));
        add_op(OP_FREE, 32'hFFFF_F000, '0, 1, make_result(STAT_OK, '0, STACK_DEPTH));
        add_op(OP_ALLOC, '0, '0, 1, make_result(STAT_OK, 32'hFFFF_F000, STACK_DEPTH - 1));
        add_op(OP_CLEAR, '0, '0, 1, make_result(STAT_OK, '0, 0));

        // Zero physical limit rejects everything.
        add_write(CFG_PHYS_TOP, '0);
        add_op(OP_FREE, '0, '0, 1, make_result(STAT_BAD, '0, 0));

        // Largest offset: the physical address is the virtual one plus one.
        add_write(CFG_KERNEL_BASE, '1);
        add_write(CFG_PHYS_TOP, 32'h0000_2000);
        add_op(OP_FREE, '0, '0, 1, make_result(STAT_OK, '0, 1));
        add_op(OP_FREE, 32'h0000_1000, '0, 1, make_result(STAT_OK, '0, 2));
        add_op(OP_FREE, 32'h0000_2000, '0, 1, make_result(STAT_BAD, '0, 2));
        add_op(OP_ALLOC, '0, '0, 1, make_result(STAT_OK, 32'h0000_1000, 1));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_write)
            begin
                settle();
                write_register(script[i].reg_index, script[i].reg_value);
            end
            else
                send_request(script[i].request, script[i].known, script[i].result);
        end

        // Random phases, each under its own setting. The stack carries over from one
        // phase to the next; allocates never look at the settings.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                    load_settings('0, 32'h8000_0000, 32'h0E00_0000);
                1:
                    load_settings('0, '0, '1);
                4:
                    // Window wraps through zero; only its top page is above the floor.
                    load_settings(32'hFFFF_F000, 32'hFFF0_0000, 32'h0020_0000);
                5:
                    // Misaligned offset: every page that window_page picks is misaligned.
                    load_settings($urandom, $urandom | 1, $urandom);
                7:
                begin
                    kb = $urandom & ~PAGE_LOW_MASK;
                    load_settings(kb, kb, $urandom);
                end
                default:
                begin
                    kb = $urandom & ~PAGE_LOW_MASK;
                    load_settings(kb + (ADDR_W'($urandom_range(0, 16)) << PAGE_SHIFT), kb,
                                  ADDR_W'($urandom_range(1, 16'h4000)) << PAGE_SHIFT);
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Now and then the sender waits until the block has drained.
                if ($urandom_range(0, 149) == 0)
                    settle();
                send_request(random_request(), 1'b0, '0);
            end
        end

        close_writes();
        settle();
        repeat (20) @(posedge clk);

        if (awaited_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
